// ===== src/i2cm_pkg.sv =====
// Shared types, codes and reset constants for the I2C master register access unit.
package i2cm_pkg;

  localparam logic [6:0] DEV_ADDR_RST   = 7'd98;
  localparam logic [7:0] POLL_LIMIT_RST = 8'd100;

  // Configuration register indexes.
  localparam logic REG_DEV_ADDR   = 1'b0;
  localparam logic REG_POLL_LIMIT = 1'b1;

  // Transaction kinds.
  localparam logic [1:0] FUNC_RD_ONE = 2'd0;
  localparam logic [1:0] FUNC_RD_RUN = 2'd1;
  localparam logic [1:0] FUNC_WR_ONE = 2'd2;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] func;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] byte_count;
    logic       sda_in;
  } in_req_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic       status;
    logic       busy_res;
  } out_res_t;

endpackage

// ===== src/i2cm_seq.sv =====
// Bus sequencer: transaction state and the per-tick step of SCL and SDA.
module i2cm_seq
  import i2cm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  in_req_t  item,
  input  logic [6:0] dev_addr,
  input  logic [7:0] poll_limit,
  output out_res_t res,
  output logic     idle
);

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_START1   = 16'h0002,
    ST_DEV      = 16'h0004,
    ST_ACK_DEV  = 16'h0008,
    ST_REG      = 16'h0010,
    ST_ACK_REG  = 16'h0020,
    ST_DATA     = 16'h0040,
    ST_ACK_DATA = 16'h0080,
    ST_START2   = 16'h0100,
    ST_RDADDR   = 16'h0200,
    ST_ACK_RD   = 16'h0400,
    ST_READ     = 16'h0800,
    ST_NEXTACK  = 16'h1000,
    ST_NACK     = 16'h2000,
    ST_STOP     = 16'h4000,
    ST_STOP_ERR = 16'h8000
  } step_t;

  step_t      step_r, step_nxt, step_e;
  logic [1:0] sub_r, sub_nxt, sub_e;
  logic [2:0] bit_r, bit_nxt, bit_e;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic [1:0] op_r, op_nxt;
  logic [7:0] hreg_r, hreg_nxt;
  logic [7:0] hwr_r, hwr_nxt;
  logic       scl_r, scl_nxt, scl_v;
  logic       sda_r, sda_nxt;
  logic       dir_r, dir_nxt;
  logic       start_cmd;
  logic       post_low;
  logic [7:0] limit_eff;
  logic       rvalid, done, stat;
  logic [7:0] rdata;

  assign limit_eff = (poll_limit == 8'd0) ? 8'd1 : poll_limit;
  assign idle      = (step_r == ST_IDLE);

  always_comb begin
    start_cmd = (step_r == ST_IDLE) && item.cmd_valid &&
                (item.func inside {FUNC_RD_ONE, FUNC_RD_RUN, FUNC_WR_ONE});
    step_e   = step_r;
    sub_e    = sub_r;
    bit_e    = bit_r;
    op_nxt   = op_r;
    hreg_nxt = hreg_r;
    hwr_nxt  = hwr_r;
    left_nxt = left_r;
    if (start_cmd) begin
      op_nxt   = item.func;
      hreg_nxt = item.reg_addr;
      hwr_nxt  = item.write_data;
      left_nxt = (item.func == FUNC_RD_ONE) ? 8'd1 : item.byte_count;
      step_e   = ST_START1;
      sub_e    = 2'd0;
      bit_e    = 3'd0;
    end

    step_nxt  = step_e;
    sub_nxt   = sub_e;
    bit_nxt   = bit_e;
    shift_nxt = shift_r;
    poll_nxt  = poll_r;
    scl_v     = scl_r;
    sda_nxt   = sda_r;
    dir_nxt   = dir_r;
    post_low  = 1'b0;
    rvalid    = 1'b0;
    rdata     = 8'd0;
    done      = 1'b0;
    stat      = 1'b0;

    case (step_e)
      ST_IDLE: begin
      end
      ST_START1, ST_START2: begin
        if (sub_e == 2'd0) begin
          dir_nxt = 1'b1;
          sda_nxt = 1'b1;
          scl_v   = 1'b1;
          sub_nxt = 2'd1;
        end else begin
          sda_nxt   = 1'b0;
          post_low  = 1'b1;
          shift_nxt = {dev_addr, (step_e == ST_START2)};
          step_nxt  = (step_e == ST_START1) ? ST_DEV : ST_RDADDR;
          sub_nxt   = 2'd0;
          bit_nxt   = 3'd0;
        end
      end
      ST_DEV, ST_REG, ST_DATA, ST_RDADDR: begin
        if (sub_e == 2'd0) begin
          dir_nxt = 1'b1;
          sda_nxt = shift_r[7];
          sub_nxt = 2'd1;
        end else if (sub_e == 2'd1) begin
          scl_v   = 1'b1;
          sub_nxt = 2'd2;
        end else begin
          scl_v     = 1'b0;
          shift_nxt = {shift_r[6:0], 1'b0};
          if (bit_e == 3'd7) begin
            poll_nxt = 8'd0;
            sub_nxt  = 2'd0;
            bit_nxt  = 3'd0;
            case (step_e)
              ST_DEV:  step_nxt = ST_ACK_DEV;
              ST_REG:  step_nxt = ST_ACK_REG;
              ST_DATA: step_nxt = ST_ACK_DATA;
              default: step_nxt = ST_ACK_RD;
            endcase
          end else begin
            bit_nxt = bit_e + 3'd1;
            sub_nxt = 2'd0;
          end
        end
      end
      ST_ACK_DEV, ST_ACK_REG, ST_ACK_DATA, ST_ACK_RD: begin
        if (sub_e == 2'd0) begin
          dir_nxt = 1'b0;
          scl_v   = 1'b1;
          sub_nxt = 2'd1;
        end else if (sub_e == 2'd1) begin
          scl_v     = 1'b1;
          shift_nxt = {7'd0, item.sda_in};
          sub_nxt   = 2'd2;
        end else begin
          scl_v   = 1'b0;
          sub_nxt = 2'd0;
          bit_nxt = 3'd0;
          if (shift_r == 8'd0) begin
            case (step_e)
              ST_ACK_DEV: begin
                shift_nxt = hreg_r;
                step_nxt  = ST_REG;
              end
              ST_ACK_REG: begin
                if (op_r == FUNC_WR_ONE) begin
                  shift_nxt = hwr_r;
                  step_nxt  = ST_DATA;
                end else begin
                  step_nxt = ST_START2;
                end
              end
              ST_ACK_DATA: step_nxt = ST_STOP;
              default:     step_nxt = (left_r != 8'd0) ? ST_READ : ST_NACK;
            endcase
          end else if ({1'b0, poll_r} + 9'd1 >= {1'b0, limit_eff}) begin
            step_nxt = ST_STOP_ERR;
          end else begin
            poll_nxt = poll_r + 8'd1;
          end
        end
      end
      ST_READ: begin
        if (sub_e == 2'd0) begin
          dir_nxt = 1'b0;
          scl_v   = 1'b1;
          sub_nxt = 2'd1;
        end else if (sub_e == 2'd1) begin
          scl_v     = 1'b1;
          shift_nxt = {shift_r[6:0], item.sda_in};
          sub_nxt   = 2'd2;
        end else begin
          scl_v   = 1'b0;
          sub_nxt = 2'd0;
          if (bit_e == 3'd7) begin
            rdata    = shift_r;
            rvalid   = 1'b1;
            left_nxt = left_r - 8'd1;
            step_nxt = (left_r != 8'd1) ? ST_NEXTACK : ST_NACK;
            bit_nxt  = 3'd0;
          end else begin
            bit_nxt = bit_e + 3'd1;
          end
        end
      end
      ST_NEXTACK, ST_NACK: begin
        if (sub_e == 2'd0) begin
          dir_nxt = 1'b1;
          sda_nxt = (step_e == ST_NACK);
          sub_nxt = 2'd1;
        end else if (sub_e == 2'd1) begin
          scl_v   = 1'b1;
          sub_nxt = 2'd2;
        end else begin
          scl_v   = 1'b0;
          sub_nxt = 2'd0;
          bit_nxt = 3'd0;
          if (step_e == ST_NEXTACK) begin
            sda_nxt  = 1'b1;
            step_nxt = ST_READ;
          end else begin
            step_nxt = ST_STOP;
          end
        end
      end
      ST_STOP, ST_STOP_ERR: begin
        if (sub_e == 2'd0) begin
          dir_nxt = 1'b1;
          sda_nxt = 1'b0;
          sub_nxt = 2'd1;
        end else if (sub_e == 2'd1) begin
          scl_v   = 1'b1;
          sub_nxt = 2'd2;
        end else if (sub_e == 2'd2) begin
          sda_nxt = 1'b1;
          sub_nxt = 2'd3;
        end else begin
          done     = 1'b1;
          stat     = (step_e == ST_STOP_ERR);
          step_nxt = ST_IDLE;
          sub_nxt  = 2'd0;
          bit_nxt  = 3'd0;
        end
      end
      default: begin
        step_nxt = ST_IDLE;
      end
    endcase

    // The start condition shows SCL high for its last tick, then lets it fall.
    scl_nxt = post_low ? 1'b0 : scl_v;

    res.scl        = scl_v;
    res.sda_out    = sda_nxt;
    res.sda_drive  = dir_nxt;
    res.read_data  = rdata;
    res.read_valid = rvalid;
    res.done_res   = done;
    res.status     = stat;
    res.busy_res   = (step_e != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_IDLE;
      sub_r   <= 2'd0;
      bit_r   <= 3'd0;
      shift_r <= 8'd0;
      left_r  <= 8'd0;
      poll_r  <= 8'd0;
      op_r    <= 2'd0;
      hreg_r  <= 8'd0;
      hwr_r   <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      dir_r   <= 1'b0;
    end else if (adv) begin
      step_r  <= step_nxt;
      sub_r   <= sub_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
      poll_r  <= poll_nxt;
      op_r    <= op_nxt;
      hreg_r  <= hreg_nxt;
      hwr_r   <= hwr_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      dir_r   <= dir_nxt;
    end
  end

endmodule

// ===== src/i2c_master_register_access_unit.sv =====
// Top level: request and result registers, configuration registers, sequencer.
// A request waits in the input register until the result register is free or being read; its result is then registered.
// Throughput: one request per cycle while results are taken; the sequencer steps once per tick request.
// While a result waits to be taken, the input register holds one more request.
// Reset (synchronous, rst_n low): bus released (SCL and SDA high, SDA input),
// sequencer idle, device address 98 and acknowledge poll limit 100.
module i2c_master_register_access_unit
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_req_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_res_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  in_req_t    in_q_r;
  logic       in_vld_r;
  out_res_t   out_q_r;
  logic       out_vld_r;
  logic [6:0] dev_addr_r;
  logic [7:0] poll_lim_r;
  logic       move;
  out_res_t   core_res;
  logic       core_idle;

  assign move      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || move;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;

  i2cm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (move),
    .item       (in_q_r),
    .dev_addr   (dev_addr_r),
    .poll_limit (poll_lim_r),
    .res        (core_res),
    .idle       (core_idle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (move) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_r <= in_data;
    end
    if (move) begin
      out_q_r <= core_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
      poll_lim_r <= POLL_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEV_ADDR:   dev_addr_r <= cfg_data[6:0];
        REG_POLL_LIMIT: poll_lim_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // A request that cannot move on stays in the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !move |=> in_vld_r)
    else $error("request dropped from input register");

  // The tick that finishes a transaction leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    move && core_res.done_res |=> core_idle)
    else $error("sequencer not idle after done");

  // An error status only comes with done, and a byte is read with SDA released.
  assert property (@(posedge clk) disable iff (!rst_n)
    move && (core_res.status || core_res.read_valid) |->
      (core_res.done_res || core_res.read_valid && !core_res.sda_drive))
    else $error("status or read byte out of place");

endmodule
